>>> rtl/lir_pkg.sv
// Shared constants, sequencer states and control types of the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_TAIL,
    ST_WAIT
  } lir_state_t;

  // Load request for the output register, with the flags of the result.
  typedef struct packed {
    logic load;
    logic run_last;
    logic block_end;
  } lir_emit_t;

endpackage

>>> rtl/linear_interp_resampler.sv
// Linear interpolation sample rate converter: one input item yields 0 to 16 result items.
// Each result is one pass through the shared multiply-add unit: issued in the run or tail
// state, handed off in the wait state; back pressure on the output stretches the hand-off.
// The output register lets the last result wait while the next input item is accepted.
// Synchronous active-low reset sets the step to 1.0 and clears history, phase and output valid.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Step register, unsigned Q4 with FRAC_BITS fraction bits.
  input  logic                                  cfg_wr_en,
  input  logic [FRAC_BITS+3:0]                  cfg_wr_data,
  // Input channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample_in, zero padding
  input  logic                                  in_tlast,   // block_last
  // Result channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,  // sample_out, zero padding
  output logic                                  out_tlast,  // run_last
  output logic                                  out_tuser   // block_end
);
  import lir_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [FRAC_BITS+3:0] STEP_ONE = (FRAC_BITS + 4)'(1) << FRAC_BITS;

  logic [FRAC_BITS+3:0]          phase_step_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;
  logic                          out_bend_r;
  logic                          out_free;

  logic                          lerp_start;
  logic signed [SAMPLE_BITS-1:0] lerp_a;
  logic signed [SAMPLE_BITS-1:0] lerp_b;
  logic        [FRAC_BITS-1:0]   lerp_frac;
  logic signed [SAMPLE_BITS-1:0] lerp_res;
  lir_emit_t                     emit;

  // The step must only be rewritten while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_ONE;
    end else if (cfg_wr_en) begin
      phase_step_r <= cfg_wr_data;
    end
  end

  // The sequencer walks the phase accumulator and hands each position to the shared unit.
  lir_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_last    (in_tlast),
    .out_free   (out_free),
    .lerp_start (lerp_start),
    .lerp_a     (lerp_a),
    .lerp_b     (lerp_b),
    .lerp_frac  (lerp_frac),
    .emit       (emit)
  );

  // One multiplier serves every result, interpolated or repeated.
  lir_lerp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk   (clk),
    .start (lerp_start),
    .a     (lerp_a),
    .b     (lerp_b),
    .frac  (lerp_frac),
    .res   (lerp_res)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_sample_r <= lerp_res;
      out_last_r   <= emit.run_last;
      out_bend_r   <= emit.block_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($unsigned(out_sample_r));
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bend_r;

endmodule

>>> rtl/lir_lerp.sv
// Shared interpolation unit: registered multiply, then rounding add.
module lir_lerp #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] res
);
  import lir_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic signed [PROD_W-1:0]      sum;

  assign diff     = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
  assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
      a_r    <= a;
    end
  end

  // The result always lies between a and b, so the slice cannot overflow.
  assign sum = (PROD_W'(a_r) <<< FRAC_BITS) + prod_r + HALF;
  assign res = sum[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];

endmodule

>>> rtl/lir_ctrl.sv
// Sequencer of the resampler: phase accumulator, sample history and output scheduling.
module lir_ctrl #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic        [FRAC_BITS+3:0]   phase_step,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  logic                          out_free,
  output logic                          lerp_start,
  output logic signed [SAMPLE_BITS-1:0] lerp_a,
  output logic signed [SAMPLE_BITS-1:0] lerp_b,
  output logic        [FRAC_BITS-1:0]   lerp_frac,
  output lir_pkg::lir_emit_t            emit
);
  import lir_pkg::*;

  localparam int POS_W  = FRAC_BITS + 5;
  localparam int STEP_W = FRAC_BITS + 4;
  localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0]  TWO_POS  = POS_W'(2) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1) << (FRAC_BITS - 3);

  lir_state_t state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          last_r, last_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic        [POS_W-1:0]       pos_r, pos_nxt;
  logic                          ret_tail_r, ret_tail_nxt;
  logic                          fin_r, fin_nxt;
  logic                          bend_r, bend_nxt;

  logic [STEP_W-1:0] step_eff;
  logic [POS_W-1:0]  pos_add;
  logic              pos_lt_one;

  assign step_eff   = (phase_step < STEP_MIN) ? STEP_MIN : phase_step;
  assign pos_add    = pos_r + {1'b0, step_eff};
  assign pos_lt_one = pos_r < ONE_POS;

  assign lerp_a    = prev_r;
  assign lerp_b    = cur_r;
  assign lerp_frac = pos_r[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      ret_tail_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      pos_r       <= pos_nxt;
      ret_tail_r  <= ret_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
    bend_r <= bend_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    pos_nxt        = pos_r;
    ret_tail_nxt   = ret_tail_r;
    fin_nxt        = fin_r;
    bend_nxt       = bend_r;
    in_ready       = 1'b0;
    lerp_start     = 1'b0;
    emit           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_nxt  = in_sample;
          last_nxt = in_last;
          if (have_prev_r) begin
            state_nxt = ST_RUN;
          end else begin
            // First sample of a block only primes the history.
            prev_nxt      = in_sample;
            have_prev_nxt = 1'b1;
            state_nxt     = in_last ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_RUN: begin
        if (pos_lt_one) begin
          lerp_start   = 1'b1;
          pos_nxt      = pos_add;
          ret_tail_nxt = 1'b0;
          // Last of the run unless the tail will still add a repeat.
          fin_nxt      = (pos_add >= ONE_POS) && !(last_r && (pos_add < TWO_POS));
          bend_nxt     = (pos_add >= ONE_POS) && !(last_r && (pos_add < TWO_POS)) && last_r;
          state_nxt    = ST_WAIT;
        end else begin
          pos_nxt   = pos_r - ONE_POS;
          prev_nxt  = cur_r;
          state_nxt = last_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        // Here prev equals cur, so the unit returns the sample itself.
        if (pos_lt_one) begin
          lerp_start   = 1'b1;
          pos_nxt      = pos_add;
          ret_tail_nxt = 1'b1;
          fin_nxt      = pos_add >= ONE_POS;
          bend_nxt     = pos_add >= ONE_POS;
          state_nxt    = ST_WAIT;
        end else begin
          prev_nxt      = '0;
          have_prev_nxt = 1'b0;
          pos_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          emit.load      = 1'b1;
          emit.run_last  = fin_r;
          emit.block_end = bend_r;
          state_nxt      = ret_tail_r ? ST_TAIL : ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> dv/linear_interp_resampler_tb.sv
// Self-checking testbench for the linear interpolation resampler with a built-in result predictor.
module linear_interp_resampler_tb;

  // Block geometry, taken from the package so the ports match the default build.
  localparam int SB         = lir_pkg::SAMPLE_BITS_DEF;
  localparam int FB         = lir_pkg::FRAC_BITS_DEF;
  localparam int DATA_W     = ((SB + 7) / 8) * 8;
  localparam int STEP_W     = FB + 4;

  // Fixed-point constants of the phase accumulator.
  localparam int ONE_Q      = 1 << FB;
  localparam int STEP_FLOOR = ONE_Q >> 3;
  localparam int MAX_RUN    = 16;

  // Step settings that the run visits by name.
  localparam logic [STEP_W-1:0] STEP_UNITY  = STEP_W'(ONE_Q);
  localparam logic [STEP_W-1:0] STEP_FINE   = STEP_W'(STEP_FLOOR);
  localparam logic [STEP_W-1:0] STEP_COARSE = STEP_W'(8 * ONE_Q);
  localparam logic [STEP_W-1:0] STEP_TOP    = '1;

  // Sample extremes.
  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // Traffic shaping and run-time bounds.
  localparam int IDLE_PCT    = 28;
  localparam int HOLD_CYCLES = 400;
  // Settle time after the last owed result, so an item with no result can still finish.
  localparam int SETTLE      = 48;
  localparam int LIMIT       = 400000;
  localparam int SHOW_MAX    = 10;

  // One source sample as the sender offers it.
  typedef struct packed {
    logic [SB-1:0] sample;
    logic          last;
  } src_item_t;

  // One interpolated sample with its flags, in the order the block emits them.
  typedef struct packed {
    logic [SB-1:0] sample;
    logic          run_last;
    logic          block_end;
  } interp_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [STEP_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata    = '0;
  logic              in_tlast    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  linear_interp_resampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Samples waiting to be offered, and interpolated samples still owed by the block.
  src_item_t src_items[$];
  interp_t   interp_due[$];

  // Shadow copy of the step register and of the converter state.
  logic [STEP_W-1:0] step_shadow = STEP_UNITY;
  logic [SB-1:0]     hist_sample = '0;
  bit                hist_valid  = 1'b0;
  int unsigned       phase_acc   = 0;

  // Traffic modes that the sequence below switches per phase.
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  // Run statistics.
  int errors       = 0;
  int items_in     = 0;
  int results_seen = 0;
  int block_ends   = 0;
  int step_writes  = 0;
  int in_stalls    = 0;
  int cycle_cnt    = 0;

  // Interpolates between two samples at a Q.FB fraction, rounding to nearest with ties
  // toward plus infinity. The arithmetic shift of the 64-bit sum gives the floor.
  function automatic logic [SB-1:0] lerp_sample(logic [SB-1:0] a, logic [SB-1:0] b,
                                                int unsigned frac);
    longint sa;
    longint sb_v;
    longint acc;
    longint shifted;
    sa      = longint'($signed(a));
    sb_v    = longint'($signed(b));
    acc     = sa * longint'(ONE_Q) + longint'(frac) * (sb_v - sa) + longint'(ONE_Q / 2);
    shifted = acc >>> FB;
    return shifted[SB-1:0];
  endfunction

  // Works out every interpolated sample that one accepted source sample causes and
  // appends them to interp_due. The step in effect is never below one eighth.
  function automatic void interpolate_item(logic [SB-1:0] cur, bit last);
    interp_t     run[$];
    interp_t     r;
    int unsigned step;
    int          n;
    step = (int'(step_shadow) < STEP_FLOOR) ? STEP_FLOOR : int'(step_shadow);
    n    = 0;
    if (hist_valid) begin
      while (phase_acc < ONE_Q && n < MAX_RUN) begin
        r = '{lerp_sample(hist_sample, cur, phase_acc), 1'b0, 1'b0};
        run.push_back(r);
        n++;
        phase_acc += step;
      end
      phase_acc -= ONE_Q;
    end
    hist_sample = cur;
    hist_valid  = 1'b1;
    if (last) begin
      // Positions left in the final interval repeat the last sample.
      while (phase_acc < ONE_Q && n < MAX_RUN) begin
        r = '{cur, 1'b0, 1'b0};
        run.push_back(r);
        n++;
        phase_acc += step;
      end
      if (n > 0) run[n-1].block_end = 1'b1;
      hist_sample = '0;
      hist_valid  = 1'b0;
      phase_acc   = 0;
    end
    if (n > 0) run[n-1].run_last = 1'b1;
    foreach (run[i]) interp_due.push_back(run[i]);
  endfunction

  // Random sample with a bias toward the extremes and toward zero crossings.
  function automatic logic [SB-1:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6)  return S_MAX;
    if (sel < 12) return S_MIN;
    if (sel < 15) return '0;
    if (sel < 18) return '1;
    return SB'($urandom);
  endfunction

  // Queues exactly count samples as whole blocks of random length, so every phase
  // closes with a sample flagged last and leaves the converter state cleared.
  task automatic queue_blocks(int count);
    int left;
    int len;
    src_item_t it;
    left = count;
    while (left > 0) begin
      // Short blocks are mixed in so first-and-last samples and tails come up often.
      len = ($urandom_range(99) < 20) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        it.sample = pick_sample();
        it.last   = (i == len - 1);
        src_items.push_back(it);
      end
      left -= len;
    end
  endtask

  task automatic queue_sample(logic [SB-1:0] s, bit last);
    src_item_t it;
    it.sample = s;
    it.last   = last;
    src_items.push_back(it);
  endtask

  // Waits until every queued sample has been taken, every owed result has arrived and
  // the block has had time to finish any item that causes no result.
  task automatic wait_idle();
    @(posedge clk);
    while (src_items.size() != 0 || in_tvalid) @(posedge clk);
    while (interp_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The register takes the value at the edge where the enable is seen high; the shadow
  // copy follows at that same edge. This is only called while the block is idle.
  task automatic write_step(logic [STEP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    step_shadow = v;
    step_writes++;
  endtask

  // Sender. A new sample is offered only once the previous one was taken, and the valid
  // stays high across back-to-back samples.
  always @(posedge clk) begin : sender
    src_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (src_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        it = src_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= DATA_W'(it.sample);
        in_tlast  <= it.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. During the hold phase it refuses results for a long stretch so that the
  // output register fills and the block pushes back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt++;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor. Both channels are sampled at the clock edge, before the drivers' new values
  // take effect. A result can never belong to a sample taken at the same edge, so the
  // prediction is made first and the check follows.
  always @(posedge clk) begin : monitor
    interp_t got;
    interp_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready) in_stalls++;
      if (in_tvalid && in_tready) begin
        interpolate_item(in_tdata[SB-1:0], in_tlast);
        items_in++;
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[SB-1:0], out_tlast, out_tuser};
        results_seen++;
        if (out_tuser) block_ends++;
        if (interp_due.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("ERROR: unexpected result sample=%0d run_last=%b block_end=%b",
                     $signed(got.sample), got.run_last, got.block_end);
        end else begin
          want = interp_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= SHOW_MAX) begin
              $display("ERROR: result %0d: expected sample=%0d run_last=%b block_end=%b,",
                       results_seen, $signed(want.sample), want.run_last, want.block_end);
              $display("       got sample=%0d run_last=%b block_end=%b",
                       $signed(got.sample), got.run_last, got.block_end);
            end
          end
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("ERROR: timeout with %0d results still owed", interp_due.size());
      $display("linear_interp_resampler test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part at the reset step of 1.0: samples must pass through one item late.
    // Full-scale swings, a block of a single sample, and a plain short block.
    queue_sample('0, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample(SB'(1), 1'b1);
    queue_sample(SB'(16'h1234), 1'b1);
    queue_sample(SB'(100), 1'b0);
    queue_sample(SB'(200), 1'b0);
    queue_sample(SB'(300), 1'b0);
    queue_sample(SB'(-500), 1'b1);
    wait_idle();

    // Finest step: eight results per interval across the full span, and a last sample
    // that yields the most results any item can cause.
    write_step(STEP_FINE);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b1);
    wait_idle();

    // Coarsest regular step: long runs of skipped samples, and a block whose last sample
    // falls where no position is left, so no result carries the block end.
    write_step(STEP_COARSE);
    queue_sample(SB'(1000), 1'b0);
    queue_sample(SB'(2000), 1'b0);
    queue_sample(SB'(3000), 1'b1);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(SB'(7), 1'b0);
    queue_sample(SB'(-7), 1'b0);
    queue_sample(S_MAX, 1'b1);
    wait_idle();

    // A step below one eighth must act as one eighth.
    write_step(STEP_W'(1000));
    queue_sample(SB'(-20000), 1'b0);
    queue_sample(SB'(20000), 1'b0);
    queue_sample(SB'(5), 1'b1);
    wait_idle();

    // Random part: well-formed blocks with random content under a new step per phase.
    // First a stretch with no idling on either side.
    write_step(STEP_W'($urandom_range(STEP_FLOOR, 2 * ONE_Q)));
    no_idle = 1'b1;
    queue_blocks(20);
    wait_idle();
    no_idle = 1'b0;

    // Long receiver hold at the finest step while the sender keeps offering.
    write_step(STEP_FINE);
    hold_go = 1'b1;
    queue_blocks(20);
    wait_idle();

    write_step(STEP_W'($urandom_range(STEP_FLOOR, 8 * ONE_Q)));
    queue_blocks(18);
    wait_idle();

    // Largest value the register holds: nearly every sample is skipped.
    write_step(STEP_TOP);
    queue_blocks(14);
    wait_idle();

    write_step(STEP_W'($urandom_range(0, STEP_FLOOR - 1)));
    queue_blocks(16);
    wait_idle();

    write_step(STEP_W'($urandom_range(STEP_FLOOR, 8 * ONE_Q)));
    queue_blocks(18);
    wait_idle();

    // Back to pass-through, written explicitly this time.
    write_step(STEP_UNITY);
    queue_blocks(18);
    wait_idle();

    if (interp_due.size() != 0) begin
      errors++;
      $display("ERROR: %0d results never arrived", interp_due.size());
    end

    $display("Summary: %0d source samples in, %0d interpolated samples checked, %0d block ends.",
             items_in, results_seen, block_ends);
    $display("Summary: %0d step writes, %0d input stall cycles, %0d mismatches.",
             step_writes, in_stalls, errors);
    if (errors == 0) begin
      $display("linear_interp_resampler test passed");
    end else begin
      $display("linear_interp_resampler test failed");
    end
    $finish;
  end

endmodule

>>> linear_interp_resampler.f
rtl/lir_pkg.sv
rtl/lir_lerp.sv
rtl/lir_ctrl.sv
rtl/linear_interp_resampler.sv
dv/linear_interp_resampler_tb.sv
